/* hw/rtl/pb64_pkg.sv */
// Shared types, codes and alphabet mapping functions for the permuted base64 codec.
`default_nettype none
package pb64_pkg;

    localparam logic [7:0] PAD_SYM = 8'h3D;
    localparam logic [7:0] DIG_PAD = 8'h40;
    localparam logic [7:0] DIG_BAD = 8'hFF;

    localparam logic [1:0] JOB_ENC = 2'd0;
    localparam logic [1:0] JOB_DEC = 2'd1;
    localparam logic [1:0] JOB_ERR = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] bits;
        logic [1:0]  last_idx;
        logic [1:0]  enc_n;
        logic        eos;
    } job_t;

    function automatic logic [7:0] digit_to_sym(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v == 6'h07) begin
            return 8'h44;
        end else if (v == 6'h0E) begin
            return 8'h68;
        end else if (v == 6'h3B) begin
            return 8'h2F;
        end else if (v >= 6'h0B && v <= 6'h24) begin
            return w + 8'h36;
        end else if (v >= 6'h2F && v <= 6'h3D) begin
            return w + 8'h3D;
        end else if (v <= 6'h0A) begin
            return w + 8'h61;
        end else if (v >= 6'h25 && v <= 6'h2E) begin
            return w + 8'h0B;
        end else if (v == 6'h3E) begin
            return 8'h2B;
        end
        return 8'h78;
    endfunction

    function automatic logic [7:0] sym_to_digit(input logic [7:0] c);
        if (c == 8'h44) begin
            return 8'h07;
        end else if (c == 8'h68) begin
            return 8'h0E;
        end else if (c == 8'h78) begin
            return 8'h3F;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            return c - 8'h36;
        end else if (c >= 8'h61 && c <= 8'h6B) begin
            return c - 8'h61;
        end else if (c >= 8'h6C && c <= 8'h7A) begin
            return c - 8'h3D;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            return c - 8'h0B;
        end else if (c == 8'h2B) begin
            return 8'h3E;
        end else if (c == 8'h2F) begin
            return 8'h3B;
        end else if (c == PAD_SYM) begin
            return DIG_PAD;
        end
        return DIG_BAD;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/pb64_front.sv */
// Front end: accepts input items, collects groups and issues output jobs.
`default_nettype none
module pb64_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_valid,
    input  wire logic          cfg_wdata,
    input  wire logic          accept,
    input  wire logic [7:0]    data_in,
    input  wire logic          eos,
    output pb64_pkg::job_t     job,
    output logic               push
);
    import pb64_pkg::*;

    logic        direction_reg;
    logic [23:0] group_bits_reg, group_bits_next;
    logic [1:0]  group_fill_reg, group_fill_next;
    logic [1:0]  pad_marks_reg, pad_marks_next;
    logic        discarding_reg, discarding_next;

    logic [2:0]  enc_n;
    logic [23:0] enc_bits;
    logic [7:0]  dig;
    logic [23:0] dec_bits;
    logic        is_pad;
    logic        job_valid;

    always_comb begin
        group_bits_next = group_bits_reg;
        group_fill_next = group_fill_reg;
        pad_marks_next  = pad_marks_reg;
        discarding_next = discarding_reg;
        job_valid       = 1'b0;
        job             = '0;
        job.eos         = eos;

        enc_n    = {1'b0, group_fill_reg} + 3'd1;
        enc_bits = {group_bits_reg[15:0], data_in};
        dig      = sym_to_digit(data_in);
        dec_bits = {group_bits_reg[17:0], dig[5:0]};
        is_pad   = (dig == DIG_PAD);

        if (discarding_reg) begin
            if (eos) begin
                discarding_next = 1'b0;
                group_bits_next = '0;
                group_fill_next = '0;
                pad_marks_next  = '0;
            end
        end else if (!direction_reg) begin
            if (enc_n < 3'd3 && !eos) begin
                group_bits_next = enc_bits;
                group_fill_next = enc_n[1:0];
            end else begin
                job_valid       = 1'b1;
                job.kind        = JOB_ENC;
                job.last_idx    = 2'd3;
                job.enc_n       = enc_n[1:0];
                unique case (enc_n[1:0])
                    2'd1:    job.bits = {enc_bits[7:0], 16'h0000};
                    2'd2:    job.bits = {enc_bits[15:0], 8'h00};
                    default: job.bits = enc_bits;
                endcase
                group_bits_next = '0;
                group_fill_next = '0;
                pad_marks_next  = '0;
            end
        end else if (dig == DIG_BAD) begin
            job_valid       = 1'b1;
            job.kind        = JOB_ERR;
            group_bits_next = '0;
            group_fill_next = '0;
            pad_marks_next  = '0;
            discarding_next = !eos;
        end else if (group_fill_reg == 2'd3) begin
            job_valid = 1'b1;
            job.kind  = JOB_DEC;
            job.bits  = dec_bits;
            if (eos && pad_marks_reg[1]) begin
                job.last_idx = 2'd0;
            end else if (eos && is_pad) begin
                job.last_idx = 2'd1;
            end else begin
                job.last_idx = 2'd2;
            end
            group_bits_next = '0;
            group_fill_next = '0;
            pad_marks_next  = '0;
        end else if (eos) begin
            job_valid       = 1'b1;
            job.kind        = JOB_ERR;
            group_bits_next = '0;
            group_fill_next = '0;
            pad_marks_next  = '0;
        end else begin
            group_bits_next = dec_bits;
            group_fill_next = group_fill_reg + 2'd1;
            if (group_fill_reg == 2'd2) begin
                pad_marks_next = {is_pad, pad_marks_reg[0]};
            end
        end
    end

    assign push = accept && job_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg  <= 1'b0;
            group_bits_reg <= '0;
            group_fill_reg <= '0;
            pad_marks_reg  <= '0;
            discarding_reg <= 1'b0;
        end else if (cfg_valid) begin
            direction_reg  <= cfg_wdata;
            group_bits_reg <= '0;
            group_fill_reg <= '0;
            pad_marks_reg  <= '0;
            discarding_reg <= 1'b0;
        end else if (accept) begin
            group_bits_reg <= group_bits_next;
            group_fill_reg <= group_fill_next;
            pad_marks_reg  <= pad_marks_next;
            discarding_reg <= discarding_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/pb64_queue.sv */
// Two-entry job queue between the front end and the back end.
`default_nettype none
module pb64_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire pb64_pkg::job_t push_job,
    input  wire logic          pop,
    output pb64_pkg::job_t     head_job,
    output logic               empty,
    output logic               full
);
    import pb64_pkg::*;

    job_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign empty    = (count_reg == 2'd0);
    assign full     = (count_reg == 2'd2);
    assign head_job = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/pb64_back.sv */
// Back end: expands each job into result transfers through an output register.
`default_nettype none
module pb64_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire pb64_pkg::job_t job,
    input  wire logic          job_valid,
    output logic               pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast,
    output logic               m_tuser
);
    import pb64_pkg::*;

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       bad_reg;

    logic       load;
    logic [5:0] digit;
    logic [7:0] data_next;
    logic       last_next;
    logic       bad_next;

    assign load = job_valid && (!valid_reg || m_tready);
    assign pop  = load && (idx_reg == job.last_idx);

    always_comb begin
        unique case (idx_reg)
            2'd0:    digit = job.bits[23:18];
            2'd1:    digit = job.bits[17:12];
            2'd2:    digit = job.bits[11:6];
            default: digit = job.bits[5:0];
        endcase
        data_next = 8'h00;
        last_next = 1'b0;
        bad_next  = 1'b0;
        unique case (job.kind)
            JOB_ENC: begin
                data_next = (idx_reg > job.enc_n) ? PAD_SYM : digit_to_sym(digit);
                last_next = job.eos && (idx_reg == 2'd3);
            end
            JOB_DEC: begin
                unique case (idx_reg)
                    2'd0:    data_next = job.bits[23:16];
                    2'd1:    data_next = job.bits[15:8];
                    default: data_next = job.bits[7:0];
                endcase
                last_next = job.eos && (idx_reg == job.last_idx);
            end
            default: begin
                last_next = 1'b1;
                bad_next  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= pop ? 2'd0 : idx_reg + 2'd1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
            last_reg <= last_next;
            bad_reg  <= bad_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = bad_reg;

endmodule
`default_nettype wire

/* hw/rtl/permuted_base64_codec.sv */
// Top level of the permuted base64 codec.
// The codec encodes bytes into symbols of a permuted 64-symbol alphabet with '=' padding,
// or decodes such symbols back into bytes, as selected by the direction register
// (0 encode, 1 decode); the user must write it over the cfg channel only while the codec
// is idle; the codec does not enforce this. Input transfers are taken one per cycle
// while the two-entry job queue has room; each completed group becomes one job, and the
// back end drives one result transfer per cycle from its output register when not stalled.
// Encoding gives four results per three bytes, so the result port sets the sustained
// encode rate; decoding gives at most three results per four symbols and runs at one
// symbol per cycle without stalls. An unknown symbol, or a decode message that ends
// inside a group, yields one result with tuser set and the rest of the message is dropped.
`default_nettype none
module permuted_base64_codec (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_wdata,     // direction
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,       // data_in
    input  wire logic       s_tlast,       // end_of_stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,       // data_out
    output logic            m_tlast,       // final_res
    output logic            m_tuser        // bad_symbol
);
    import pb64_pkg::*;

    job_t front_job;
    job_t head_job;
    logic push;
    logic pop;
    logic empty;
    logic full;
    logic accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !full;
    assign accept    = s_tvalid && s_tready;

    pb64_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .data_in   (s_tdata),
        .eos       (s_tlast),
        .job       (front_job),
        .push      (push)
    );

    pb64_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (front_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (empty),
        .full     (full)
    );

    pb64_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job       (head_job),
        .job_valid (!empty),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the permuted base64 codec, covering encode and decode streams.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pb64_pkg::*;

    localparam logic DIR_ENC = 1'b0;
    localparam logic DIR_DEC = 1'b1;
    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES = 300;
    localparam logic [8*64-1:0] ALPHABET =
        "abcdefgDijkABChEFGHIJKLMNOPQRSTUVWXYZ0123456789lmnopqrstuvw/yz+x";

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       bad;
    } codec_out_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tready = 1'b0;
    logic       cfg_ready;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    logic        dir_mode;
    logic [23:0] grp_bits;
    logic [1:0]  grp_fill;
    logic [1:0]  pad_flags;
    logic        skipping;
    logic [7:0]  sym_digit [256];
    codec_out_t  pending_out [$];

    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_left = 0;
    int          mismatches = 0;
    int unsigned cycle_count = 0;

    permuted_base64_codec dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic logic [7:0] digit_symbol(input logic [5:0] dig);
        return ALPHABET[8*(63 - int'(dig)) +: 8];
    endfunction

    function automatic void clear_group();
        grp_bits = '0;
        grp_fill = '0;
        pad_flags = '0;
        skipping = 1'b0;
    endfunction

    function automatic void push_out(input logic [7:0] data, input logic fin, input logic bad);
        pending_out.push_back(codec_out_t'{data, fin, bad});
    endfunction

    // Advances the local copy of the codec state by one accepted input transfer.
    function automatic void codec_step(input logic [7:0] d, input logic eos);
        logic [23:0] bits;
        logic [7:0]  dig;
        int          n;
        int          keep;
        if (skipping) begin
            if (eos) clear_group();
            return;
        end
        if (dir_mode == DIR_ENC) begin
            grp_bits = {grp_bits[15:0], d};
            n = int'(grp_fill) + 1;
            if (n < 3 && !eos) begin
                grp_fill = n[1:0];
                return;
            end
            bits = grp_bits << (8 * (3 - n));
            for (int i = 0; i < 4; i++) begin
                push_out(i > n ? PAD_SYM : digit_symbol(bits[18 - 6*i +: 6]),
                         eos && i == 3, 1'b0);
            end
            clear_group();
            return;
        end
        dig = sym_digit[d];
        if (dig == DIG_BAD) begin
            push_out(8'h00, 1'b1, 1'b1);
            clear_group();
            if (!eos) skipping = 1'b1;
            return;
        end
        grp_bits = {grp_bits[17:0], dig[5:0]};
        if (grp_fill == 2'd2) pad_flags[1] = (dig == DIG_PAD);
        if (grp_fill == 2'd3) pad_flags[0] = (dig == DIG_PAD);
        n = int'(grp_fill) + 1;
        if (n == 4) begin
            keep = !eos ? 3 : pad_flags[1] ? 1 : pad_flags[0] ? 2 : 3;
            for (int i = 0; i < keep; i++) begin
                push_out(grp_bits[16 - 8*i +: 8], eos && i + 1 == keep, 1'b0);
            end
            clear_group();
            return;
        end
        if (eos) begin
            push_out(8'h00, 1'b1, 1'b1);
            clear_group();
            return;
        end
        grp_fill = n[1:0];
    endfunction

    task automatic send_item(input logic [7:0] d, input logic eos);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tlast <= eos;
        do @(posedge aclk); while (!s_tready);
        codec_step(d, eos);
    endtask

    task automatic send_text(input string txt, input logic eos_at_end);
        for (int i = 0; i < txt.len(); i++) begin
            send_item(txt[i], eos_at_end && i == txt.len() - 1);
        end
    endtask

    task automatic wait_idle(input int settle);
        s_tvalid <= 1'b0;
        while (pending_out.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_direction(input logic value);
        wait_idle(SETTLE_CYCLES);
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        dir_mode = value;
        clear_group();
    endtask

    task automatic send_enc_message(input int len);
        for (int i = 0; i < len; i++) begin
            send_item(8'($urandom_range(255)), i == len - 1);
        end
    endtask

    // Mostly well-formed symbol groups, with stray bytes, stray pads and cut-off endings.
    task automatic send_dec_message(input int groups);
        int         pads;
        int         total;
        int         cut;
        logic [7:0] sym;
        pads = $urandom_range(2);
        total = 4 * groups;
        cut = ($urandom_range(9) == 0) ? $urandom_range(total - 1, 1) : total;
        for (int i = 0; i < cut; i++) begin
            sym = digit_symbol(6'($urandom_range(63)));
            if (i >= total - pads) sym = PAD_SYM;
            if ($urandom_range(39) == 0) sym = PAD_SYM;
            if ($urandom_range(29) == 0) sym = 8'($urandom_range(255));
            send_item(sym, i == cut - 1);
        end
    endtask

    task automatic test_encode_edges();
        write_direction(DIR_ENC);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
    endtask

    task automatic test_decode_padding();
        write_direction(DIR_DEC);
        send_text("ab==", 1'b0);
        send_text("xy+=", 1'b1);
        send_text("09=+", 1'b1);
    endtask

    task automatic test_decode_errors();
        send_item("k", 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item("a", 1'b1);
        send_item(8'h7B, 1'b1);
        send_text("lm", 1'b1);
    endtask

    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        write_direction(DIR_ENC);
        hold_left = HOLD_CYCLES;
        send_enc_message(48);
    endtask

    task automatic test_sender_pause();
        write_direction(DIR_ENC);
        for (int i = 0; i < 5; i++) send_item(8'($urandom_range(255)), 1'b0);
        wait_idle(0);
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic test_random_phase(input int sender_idle, input int receiver_stall);
        idle_pct = sender_idle;
        stall_pct = receiver_stall;
        write_direction(DIR_ENC);
        repeat (5) send_enc_message($urandom_range(8, 1));
        write_direction(DIR_DEC);
        repeat (3) send_dec_message($urandom_range(3, 1));
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        codec_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_out.size() == 0) begin
                $display("%0t: unexpected transfer data=%02h last=%b user=%b",
                         $time, m_tdata, m_tlast, m_tuser);
                mismatches++;
            end else begin
                want = pending_out.pop_front();
                if (want.data !== m_tdata || want.fin !== m_tlast || want.bad !== m_tuser) begin
                    $display("%0t: expected data=%02h last=%b user=%b, got data=%02h last=%b user=%b",
                             $time, want.data, want.fin, want.bad, m_tdata, m_tlast, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) @(posedge aclk);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        for (int c = 0; c < 256; c++) sym_digit[c] = DIG_BAD;
        for (int d = 0; d < 64; d++) sym_digit[digit_symbol(6'(d))] = 8'(d);
        sym_digit[PAD_SYM] = DIG_PAD;
        dir_mode = DIR_ENC;
        clear_group();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_encode_edges();
        test_decode_padding();
        test_decode_errors();
        test_backpressure();
        test_sender_pause();
        test_random_phase(0, 0);
        test_random_phase(60, 0);
        test_random_phase(0, 60);
        test_random_phase(9, 9);

        wait_idle(SETTLE_CYCLES);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
